// File: src/sbtm_pkg.sv
package sbtm_pkg;

  localparam int unsigned DEF_BANKS      = 4;
  localparam int unsigned DEF_ELEM_BITS  = 16;
  localparam int unsigned DEF_BANK_DEPTH = 1024;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned DATA_W  = 64;

  typedef enum logic [2:0] {
    OP_RD2D   = 3'd0,
    OP_WR2D   = 3'd1,
    OP_RDONE  = 3'd2,
    OP_WRONE  = 3'd3,
    OP_RDWIDE = 3'd4,
    OP_WRWIDE = 3'd5
  } op_t;

  localparam logic [1:0] REG_RD_BASE   = 2'd0;
  localparam logic [1:0] REG_RD_STRIDE = 2'd1;
  localparam logic [1:0] REG_WR_BASE   = 2'd2;
  localparam logic [1:0] REG_WR_STRIDE = 2'd3;

  typedef struct packed {
    logic rd;
    logic single;
  } ctrl_t;

endpackage

// File: src/sbtm_ram.sv
module sbtm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/sbtm_queue.sv
module sbtm_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic             head_v;
  logic             tail_v;
  logic [WIDTH-1:0] head;
  logic [WIDTH-1:0] tail;
  logic             push;
  logic             pop;

  assign push_ready = !tail_v;
  assign pop_valid  = head_v;
  assign pop_data   = head;
  assign push       = push_valid && push_ready;
  assign pop        = head_v && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      tail_v <= 1'b0;
    end else if (pop) begin
      if (tail_v) begin
        head   <= tail;
        head_v <= 1'b1;
        tail_v <= push;
        if (push) begin
          tail <= push_data;
        end
      end else begin
        head_v <= push;
        if (push) begin
          head <= push_data;
        end
      end
    end else if (push) begin
      if (head_v) begin
        tail   <= push_data;
        tail_v <= 1'b1;
      end else begin
        head   <= push_data;
        head_v <= 1'b1;
      end
    end
  end

  a_tail_needs_head: assert property (@(posedge clk) disable iff (rst)
    tail_v |-> head_v) else $error("queue tail held without head");

endmodule

// File: src/sbtm_front.sv
module sbtm_front #(
  parameter int unsigned BANKS      = sbtm_pkg::DEF_BANKS,
  parameter int unsigned ELEM_BITS  = sbtm_pkg::DEF_ELEM_BITS,
  parameter int unsigned BANK_DEPTH = sbtm_pkg::DEF_BANK_DEPTH,
  localparam int unsigned BW = $clog2(BANKS),
  localparam int unsigned AW = $clog2(BANK_DEPTH),
  localparam int unsigned DW = BANKS * ELEM_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            opcode,
  input  logic [11:0]           col_x,
  input  logic [11:0]           row_y,
  input  logic                  vertical,
  input  logic [11:0]           offset,
  input  logic [63:0]           write_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [11:0]           cfg_data,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output sbtm_pkg::ctrl_t       cmd_ctrl,
  output logic [BW-1:0]         cmd_rot,
  output logic [BANKS*AW-1:0]   cmd_addr,
  output logic [BANKS-1:0]      cmd_we,
  output logic [DW-1:0]         cmd_wdata
);

  localparam int unsigned DN = 26;
  localparam int unsigned SH = DN + BW;
  localparam logic [DN:0] RECIP = (DN+1)'(((64'd1 << SH) + 64'(BANKS) - 64'd1) / 64'(BANKS));
  localparam logic [DN-1:0] MASK = DN'(BANK_DEPTH - 1);
  localparam int unsigned LW = (DW > 64) ? DW : 64;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_PUSH} state_t;

  function automatic logic [DN-1:0] div_b(input logic [DN-1:0] v);
    logic [2*DN:0] p;
    p = (2*DN+1)'(v) * (2*DN+1)'(RECIP);
    return p[SH+DN-1:SH];
  endfunction

  state_t            state;
  sbtm_pkg::op_t     op;
  logic [11:0]       x;
  logic [11:0]       y;
  logic              vert;
  logic [11:0]       off;
  logic [DW-1:0]     lanes;
  logic [11:0]       base;
  logic [11:0]       stride;
  logic [11:0]       read_base;
  logic [11:0]       read_stride;
  logic [11:0]       write_base;
  logic [11:0]       write_stride;
  logic [DN-1:0]     prod [BANKS];
  logic [DN-1:0]     lq   [BANKS];
  logic [12:0]       xy;
  logic [12:0]       ad;
  logic [DN-1:0]     xyq;
  logic [DN-1:0]     adq;
  logic [DN-1:0]     bq;

  logic [LW-1:0]     wide_in;
  logic              is_rd;
  logic              is_2d;
  logic              is_one;
  logic [12:0]       xy_rem;
  logic [12:0]       ad_rem;
  logic [BW-1:0]     rot;
  logic [DN-1:0]     one_word;
  logic [BANKS*AW-1:0] words;
  logic [2*BANKS*AW-1:0] words_sh;
  logic [2*DW-1:0]   data_sh;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign wide_in   = LW'(write_data);

  always_comb begin
    is_rd  = (op == sbtm_pkg::OP_RD2D) || (op == sbtm_pkg::OP_RDONE)
          || (op == sbtm_pkg::OP_RDWIDE);
    is_2d  = (op == sbtm_pkg::OP_RD2D) || (op == sbtm_pkg::OP_WR2D);
    is_one = (op == sbtm_pkg::OP_RDONE) || (op == sbtm_pkg::OP_WRONE);
    xy_rem = xy - xyq[12:0] * 13'(BANKS);
    ad_rem = ad - adq[12:0] * 13'(BANKS);
    if (is_2d) begin
      rot = xy_rem[BW-1:0];
    end else if (is_one) begin
      rot = ad_rem[BW-1:0];
    end else begin
      rot = '0;
    end
    one_word = adq & MASK;
    for (int i = 0; i < BANKS; i++) begin
      if (is_2d) begin
        words[i*AW +: AW] = AW'((bq + lq[i]) & MASK);
      end else begin
        words[i*AW +: AW] = one_word[AW-1:0];
      end
    end
    words_sh = {words, words} << (int'(rot) * AW);
    data_sh  = {lanes, lanes} << (int'(rot) * ELEM_BITS);
    for (int k = 0; k < BANKS; k++) begin
      cmd_we[k] = !is_rd && (!is_one || (BW'(k) == rot));
    end
  end

  assign cmd_valid       = (state == S_PUSH);
  assign cmd_ctrl.rd     = is_rd;
  assign cmd_ctrl.single = is_one;
  assign cmd_rot         = rot;
  assign cmd_addr        = words_sh[2*BANKS*AW-1:BANKS*AW];
  assign cmd_wdata       = data_sh[2*DW-1:DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      read_base    <= '0;
      read_stride  <= '0;
      write_base   <= '0;
      write_stride <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          sbtm_pkg::REG_RD_BASE:   read_base    <= cfg_data;
          sbtm_pkg::REG_RD_STRIDE: read_stride  <= cfg_data;
          sbtm_pkg::REG_WR_BASE:   write_base   <= cfg_data;
          sbtm_pkg::REG_WR_STRIDE: write_stride <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && opcode <= sbtm_pkg::OP_WRWIDE) begin
            state  <= S_MUL;
            op     <= sbtm_pkg::op_t'(opcode);
            x      <= col_x;
            y      <= row_y;
            vert   <= vertical;
            off    <= offset;
            lanes  <= wide_in[DW-1:0];
            base   <= opcode[0] ? write_base : read_base;
            stride <= opcode[0] ? write_stride : read_stride;
          end
        end
        S_MUL: begin
          for (int i = 0; i < BANKS; i++) begin
            prod[i] <= (vert ? (13'(y) + 13'(i)) : 13'(y)) * DN'(stride) + DN'(x);
          end
          xy    <= 13'(x) + 13'(y);
          ad    <= 13'(base) + 13'(off);
          state <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < BANKS; i++) begin
            lq[i] <= div_b(prod[i]);
          end
          xyq   <= div_b(DN'(xy));
          adq   <= div_b(DN'(ad));
          bq    <= div_b(DN'(base));
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (cmd_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/sbtm_back.sv
module sbtm_back #(
  parameter int unsigned BANKS      = sbtm_pkg::DEF_BANKS,
  parameter int unsigned ELEM_BITS  = sbtm_pkg::DEF_ELEM_BITS,
  parameter int unsigned BANK_DEPTH = sbtm_pkg::DEF_BANK_DEPTH,
  localparam int unsigned BW = $clog2(BANKS),
  localparam int unsigned AW = $clog2(BANK_DEPTH),
  localparam int unsigned DW = BANKS * ELEM_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  sbtm_pkg::ctrl_t     cmd_ctrl,
  input  logic [BW-1:0]       cmd_rot,
  input  logic [BANKS*AW-1:0] cmd_addr,
  input  logic [BANKS-1:0]    cmd_we,
  input  logic [DW-1:0]       cmd_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         read_data
);

  localparam int unsigned LW = (DW > 64) ? DW : 64;

  logic          pop;
  logic          pend;
  logic [BW-1:0] pend_rot;
  logic          pend_single;
  logic [DW-1:0] bank_rd;
  logic [2*DW-1:0] rd_sh;
  logic [DW-1:0] lanes;
  logic [LW-1:0] full;

  assign cmd_ready = !pend && (!cmd_ctrl.rd || !out_valid);
  assign pop       = cmd_valid && cmd_ready;

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    sbtm_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (pop && cmd_we[k]),
      .addr  (cmd_addr[k*AW +: AW]),
      .wdata (cmd_wdata[k*ELEM_BITS +: ELEM_BITS]),
      .rdata (bank_rd[k*ELEM_BITS +: ELEM_BITS])
    );
  end

  always_comb begin
    rd_sh = {bank_rd, bank_rd} >> (int'(pend_rot) * ELEM_BITS);
    lanes = rd_sh[DW-1:0];
    if (pend_single) begin
      lanes = {{(DW-ELEM_BITS){1'b0}}, lanes[ELEM_BITS-1:0]};
    end
    full = LW'(lanes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= pop && cmd_ctrl.rd;
      if (pop) begin
        pend_rot    <= cmd_rot;
        pend_single <= cmd_ctrl.single;
      end
      if (pend) begin
        out_valid <= 1'b1;
        read_data <= full[63:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pend_slot_free: assert property (@(posedge clk) disable iff (rst)
    pend |-> !out_valid) else $error("read returned into a full output slot");
  a_pend_delivers: assert property (@(posedge clk) disable iff (rst)
    pend |=> out_valid) else $error("read data not presented");
  a_read_issue: assert property (@(posedge clk) disable iff (rst)
    (pop && cmd_ctrl.rd) |-> (!pend && !out_valid)) else $error("read issued while busy");

endmodule

// File: src/skewed_bank_transpose_memory_core.sv
// Skewed bank memory for transposition: element (x,y) sits in bank (x+y) mod BANKS,
// so a full row or column of BANKS elements moves in one bank access; single and
// wide linear modes are also offered. An item passes through four steps in the front
// sequencer (capture, row times stride multiply, reciprocal divide by BANKS, issue),
// and no new item is accepted until the last one has issued; an issued read passes
// through the registered read of the bank RAMs and then the read_data register. A
// two-entry queue separates address generation from the banks. Reading a location
// never written returns undefined data.
module skewed_bank_transpose_memory_core #(
  parameter int unsigned BANKS      = sbtm_pkg::DEF_BANKS,
  parameter int unsigned ELEM_BITS  = sbtm_pkg::DEF_ELEM_BITS,
  parameter int unsigned BANK_DEPTH = sbtm_pkg::DEF_BANK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [11:0] col_x,
  input  logic [11:0] row_y,
  input  logic        vertical,
  input  logic [11:0] offset,
  input  logic [63:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int unsigned BW = $clog2(BANKS);
  localparam int unsigned AW = $clog2(BANK_DEPTH);
  localparam int unsigned DW = BANKS * ELEM_BITS;
  localparam int unsigned QW = 2 + BW + BANKS*AW + BANKS + DW;

  logic                f_valid;
  logic                f_ready;
  sbtm_pkg::ctrl_t     f_ctrl;
  logic [BW-1:0]       f_rot;
  logic [BANKS*AW-1:0] f_addr;
  logic [BANKS-1:0]    f_we;
  logic [DW-1:0]       f_wdata;
  logic                b_valid;
  logic                b_ready;
  sbtm_pkg::ctrl_t     b_ctrl;
  logic [BW-1:0]       b_rot;
  logic [BANKS*AW-1:0] b_addr;
  logic [BANKS-1:0]    b_we;
  logic [DW-1:0]       b_wdata;
  logic [QW-1:0]       q_in;
  logic [QW-1:0]       q_out;

  sbtm_front #(
    .BANKS      (BANKS),
    .ELEM_BITS  (ELEM_BITS),
    .BANK_DEPTH (BANK_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .col_x      (col_x),
    .row_y      (row_y),
    .vertical   (vertical),
    .offset     (offset),
    .write_data (write_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd_ctrl   (f_ctrl),
    .cmd_rot    (f_rot),
    .cmd_addr   (f_addr),
    .cmd_we     (f_we),
    .cmd_wdata  (f_wdata)
  );

  assign q_in = {f_ctrl, f_rot, f_addr, f_we, f_wdata};
  assign {b_ctrl, b_rot, b_addr, b_we, b_wdata} = q_out;

  sbtm_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_in),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_out)
  );

  sbtm_back #(
    .BANKS      (BANKS),
    .ELEM_BITS  (ELEM_BITS),
    .BANK_DEPTH (BANK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (b_valid),
    .cmd_ready  (b_ready),
    .cmd_ctrl   (b_ctrl),
    .cmd_rot    (b_rot),
    .cmd_addr   (b_addr),
    .cmd_we     (b_we),
    .cmd_wdata  (b_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data)
  );

endmodule
